>>> hdl/pdsel_pkg.sv
// ----------------------------------------------------------------------------
// pdsel_pkg: USB-PD source capability selector definitions
// Object field layout, type codes, tiebreak codes, register indexes and
// register reset values shared by the selector RTL.
// ----------------------------------------------------------------------------
package pdsel_pkg;

    // List geometry
    localparam int MAX_OBJECTS   = 16;
    localparam int POS_W         = 4;
    localparam int SPR_POSITIONS = 7;

    // Field widths
    localparam int OBJ_W   = 32;
    localparam int MV_W    = 16;
    localparam int MA_W    = 14;
    localparam int UW_W    = 29;
    localparam int CAP_W   = 28;
    localparam int OPA_W   = 14;
    localparam int OPB_W   = 18;
    localparam int PROD_W  = OPA_W + OPB_W;
    localparam int CFG_A_W = 3;
    localparam int CFG_D_W = 18;

    // Unit scaling
    localparam int MV_PER_UNIT         = 50;
    localparam int MA_PER_UNIT         = 10;
    localparam int UW_PER_BATTERY_UNIT = 250000;
    localparam int UW_PER_MW           = 1000;

    // Object type codes, bits 31:30
    typedef logic [1:0] pdo_type_t;
    localparam pdo_type_t PDO_FIXED     = 2'd0;
    localparam pdo_type_t PDO_BATTERY   = 2'd1;
    localparam pdo_type_t PDO_VARIABLE  = 2'd2;
    localparam pdo_type_t PDO_AUGMENTED = 2'd3;

    // Equal power tiebreak codes
    typedef logic [1:0] tie_mode_t;
    localparam tie_mode_t TIE_NONE = 2'd0;
    localparam tie_mode_t TIE_LOW  = 2'd1;
    localparam tie_mode_t TIE_HIGH = 2'd2;

    // Register indexes
    typedef logic [CFG_A_W-1:0] cfg_addr_t;
    localparam cfg_addr_t CFG_REQUEST_LIMIT = 3'd0;
    localparam cfg_addr_t CFG_CURRENT_LIMIT = 3'd1;
    localparam cfg_addr_t CFG_POWER_LIMIT   = 3'd2;
    localparam cfg_addr_t CFG_SPR_LIMIT     = 3'd3;
    localparam cfg_addr_t CFG_VALID_MIN     = 3'd4;
    localparam cfg_addr_t CFG_VALID_MAX     = 3'd5;
    localparam cfg_addr_t CFG_TIE_MODE      = 3'd6;
    localparam cfg_addr_t CFG_FIXED_ONLY    = 3'd7;

    // Register reset values
    localparam logic [MV_W-1:0]  RST_REQUEST_LIMIT = 16'd20000;
    localparam logic [MA_W-1:0]  RST_CURRENT_LIMIT = 14'd3000;
    localparam logic [CAP_W-1:0] RST_POWER_CAP     = 28'd60000000;
    localparam logic [MV_W-1:0]  RST_SPR_LIMIT     = 16'd20000;
    localparam logic [MV_W-1:0]  RST_VALID_MIN     = 16'd0;
    localparam logic [MV_W-1:0]  RST_VALID_MAX     = 16'd51150;

endpackage

>>> hdl/usb_pd_source_cap_selector.sv
// ----------------------------------------------------------------------------
// usb_pd_source_cap_selector: pick the best USB-PD source capability
// Filters the source's power data objects, rates each one in microwatts and
// reports the best object once the list is complete.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (s_valid/s_ready): one 32-bit source capability per item,
//   with s_last_object high on the final capability of the list.
//   Result channel (m_valid/m_ready): one item per list, carrying the chosen
//   position, the chosen object word and its power in microwatts. If nothing
//   qualifies, the result is position 0, the first word and power 0.
//   Config port (cfg_wr_en/cfg_addr/cfg_wdata): single-cycle writes, only
//   while no list is in flight.
// Timing
//   An input item lands in an input register; from there the filter, the
//   single 14x18 power multiplier and the best-so-far compare update the
//   scan state. The result is registered on m_* as the last item leaves the
//   input register. One item is taken every cycle unless a last item is held
//   in the input register, as described below.
// Reset and stall
//   aresetn (synchronous, active low) loads register defaults and clears the
//   scan. While a result waits on m_ready, items that are not the end of a
//   list keep flowing; a second last item holds in the input register until
//   the result register frees up.
// ----------------------------------------------------------------------------
module usb_pd_source_cap_selector
    import pdsel_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_A_W-1:0]    cfg_addr,
    input  logic [CFG_D_W-1:0]    cfg_wdata,
    // capability items
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [OBJ_W-1:0]      s_power_object,
    input  logic                  s_last_object,
    // result items
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [POS_W-1:0]      m_chosen_index,
    output logic [OBJ_W-1:0]      m_chosen_object,
    output logic [UW_W-1:0]       m_chosen_power_uw
);

    // ------------------------------------------------------------------
    // Configuration registers. The power cap is kept already scaled to uW.
    // ------------------------------------------------------------------
    logic [MV_W-1:0]  request_limit_reg;
    logic [MA_W-1:0]  current_limit_reg;
    logic [CAP_W-1:0] power_cap_reg;
    logic [MV_W-1:0]  spr_limit_reg;
    logic [MV_W-1:0]  valid_min_reg;
    logic [MV_W-1:0]  valid_max_reg;
    tie_mode_t        tie_mode_reg;
    logic             fixed_only_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            request_limit_reg <= RST_REQUEST_LIMIT;
            current_limit_reg <= RST_CURRENT_LIMIT;
            power_cap_reg     <= RST_POWER_CAP;
            spr_limit_reg     <= RST_SPR_LIMIT;
            valid_min_reg     <= RST_VALID_MIN;
            valid_max_reg     <= RST_VALID_MAX;
            tie_mode_reg      <= TIE_NONE;
            fixed_only_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_REQUEST_LIMIT: request_limit_reg <= cfg_wdata[MV_W-1:0];
                CFG_CURRENT_LIMIT: current_limit_reg <= cfg_wdata[MA_W-1:0];
                CFG_POWER_LIMIT: begin
                    power_cap_reg <= CAP_W'(CAP_W'(cfg_wdata) * CAP_W'(UW_PER_MW));
                end
                CFG_SPR_LIMIT:     spr_limit_reg     <= cfg_wdata[MV_W-1:0];
                CFG_VALID_MIN:     valid_min_reg     <= cfg_wdata[MV_W-1:0];
                CFG_VALID_MAX:     valid_max_reg     <= cfg_wdata[MV_W-1:0];
                CFG_TIE_MODE:      tie_mode_reg      <= cfg_wdata[1:0];
                CFG_FIXED_ONLY:    fixed_only_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input stage: decode the word into voltage and multiplier operands.
    // Battery objects multiply their 250 mW count by 250000 uW; the others
    // multiply the clamped current by the voltage.
    // ------------------------------------------------------------------
    pdo_type_t        in_type;
    logic [MV_W-1:0]  in_mv;
    logic [MA_W-1:0]  in_ma_raw;
    logic [MA_W-1:0]  in_ma;
    logic [OPA_W-1:0] in_opa;
    logic [OPB_W-1:0] in_opb;

    assign in_type   = s_power_object[31:30];
    assign in_mv     = MV_W'({6'd0, s_power_object[19:10]} * MV_W'(MV_PER_UNIT));
    assign in_ma_raw = MA_W'({4'd0, s_power_object[9:0]} * MA_W'(MA_PER_UNIT));
    assign in_ma     = (in_ma_raw > current_limit_reg) ? current_limit_reg : in_ma_raw;

    always_comb begin
        if (in_type == PDO_BATTERY) begin
            in_opa = OPA_W'(s_power_object[9:0]);
            in_opb = OPB_W'(UW_PER_BATTERY_UNIT);
        end else begin
            in_opa = in_ma;
            in_opb = OPB_W'(in_mv);
        end
    end

    logic             s1_valid_reg;
    logic             s1_last_reg;
    logic [OBJ_W-1:0] s1_obj_reg;
    pdo_type_t        s1_type_reg;
    logic [MV_W-1:0]  s1_mv_reg;
    logic [OPA_W-1:0] s1_opa_reg;
    logic [OPB_W-1:0] s1_opb_reg;

    logic out_free;
    logic s1_adv;
    logic s1_fire;
    logic s_fire;

    // A last item moves on only when the result register can take it.
    assign out_free = !m_valid || m_ready;
    assign s1_adv   = !s1_last_reg || out_free;
    assign s1_fire  = s1_valid_reg && s1_adv;
    assign s_ready  = !s1_valid_reg || s1_adv;
    assign s_fire   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_last_reg <= s_last_object;
            s1_obj_reg  <= s_power_object;
            s1_type_reg <= in_type;
            s1_mv_reg   <= in_mv;
            s1_opa_reg  <= in_opa;
            s1_opb_reg  <= in_opb;
        end
    end

    // ------------------------------------------------------------------
    // Scan state
    // ------------------------------------------------------------------
    logic [POS_W-1:0] position_reg;
    logic             full_reg;
    logic [POS_W-1:0] best_index_reg;
    logic [UW_W-1:0]  best_power_reg;
    logic [MV_W-1:0]  best_voltage_reg;
    logic [OBJ_W-1:0] best_object_reg;

    // ------------------------------------------------------------------
    // Evaluate stage: filter, power, cap and compare against the best.
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] prod_uw;
    logic [UW_W-1:0]   capped_uw;
    logic              skip;
    logic              tie_win;
    logic              take;

    assign prod_uw   = PROD_W'(s1_opa_reg) * PROD_W'(s1_opb_reg);
    assign capped_uw = (prod_uw > PROD_W'(power_cap_reg)) ? UW_W'(power_cap_reg)
                                                          : UW_W'(prod_uw);

    assign skip = (s1_type_reg == PDO_AUGMENTED)
               || (fixed_only_reg && (s1_type_reg != PDO_FIXED))
               || (s1_mv_reg == '0)
               || ((position_reg < POS_W'(SPR_POSITIONS)) && (s1_mv_reg > spr_limit_reg))
               || (s1_mv_reg < valid_min_reg)
               || (s1_mv_reg > valid_max_reg)
               || (s1_mv_reg > request_limit_reg);

    always_comb begin
        case (tie_mode_reg)
            TIE_LOW:  tie_win = (capped_uw == best_power_reg) && (s1_mv_reg < best_voltage_reg);
            TIE_HIGH: tie_win = (capped_uw == best_power_reg) && (s1_mv_reg > best_voltage_reg);
            default:  tie_win = 1'b0;
        endcase
    end

    // Once the list overflows, further items are ignored up to the last one.
    assign take = !full_reg && !skip && ((capped_uw > best_power_reg) || tie_win);

    logic [POS_W-1:0] best_index_next;
    logic [UW_W-1:0]  best_power_next;
    logic [MV_W-1:0]  best_voltage_next;
    logic [OBJ_W-1:0] best_object_next;

    always_comb begin
        best_index_next   = best_index_reg;
        best_power_next   = best_power_reg;
        best_voltage_next = best_voltage_reg;
        best_object_next  = best_object_reg;
        // The first word stands as the fallback choice.
        if (!full_reg && (position_reg == '0)) begin
            best_object_next = s1_obj_reg;
        end
        if (take) begin
            best_index_next   = position_reg;
            best_power_next   = capped_uw;
            best_voltage_next = s1_mv_reg;
            best_object_next  = s1_obj_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg     <= '0;
            full_reg         <= 1'b0;
            best_index_reg   <= '0;
            best_power_reg   <= '0;
            best_voltage_reg <= '0;
            best_object_reg  <= '0;
        end else if (s1_fire) begin
            if (s1_last_reg) begin
                // End of list: clear the scan for the next one.
                position_reg     <= '0;
                full_reg         <= 1'b0;
                best_index_reg   <= '0;
                best_power_reg   <= '0;
                best_voltage_reg <= '0;
                best_object_reg  <= '0;
            end else begin
                if (!full_reg) begin
                    if (position_reg == POS_W'(MAX_OBJECTS - 1)) begin
                        full_reg <= 1'b1;
                    end else begin
                        position_reg <= position_reg + 1'b1;
                    end
                end
                best_index_reg   <= best_index_next;
                best_power_reg   <= best_power_next;
                best_voltage_reg <= best_voltage_next;
                best_object_reg  <= best_object_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic             m_valid_reg;
    logic [POS_W-1:0] m_index_reg;
    logic [OBJ_W-1:0] m_object_reg;
    logic [UW_W-1:0]  m_power_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_fire && s1_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && s1_last_reg) begin
            m_index_reg  <= best_index_next;
            m_object_reg <= best_object_next;
            m_power_reg  <= best_power_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_chosen_index    = m_index_reg;
    assign m_chosen_object   = m_object_reg;
    assign m_chosen_power_uw = m_power_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_full_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        full_reg |-> (position_reg == POS_W'(MAX_OBJECTS - 1)))
        else $error("full flag set before the final position");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && s1_last_reg && m_valid && !m_ready))
        else $error("input stalled without a blocked end of list");

    a_scan_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && s1_last_reg) |=>
            (position_reg == '0) && !full_reg && (best_power_reg == '0) && m_valid)
        else $error("scan not cleared or result not posted after end of list");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the USB-PD source capability selector
// Feeds capability lists through the valid/ready input, predicts the chosen
// capability of every list, and checks each result item field by field.
// The run steps through several limit settings, including the extremes.
// Both sides idle at random, and one long result stall backs up the input.
// ----------------------------------------------------------------------------
module tb_top;
    import pdsel_pkg::*;

    localparam int        CYCLE_LIMIT   = 200000;
    localparam int        SETTLE_CYCLES = 8;
    localparam int        HOLD_CYCLES   = 300;
    // Tie code with no meaning of its own; the block must treat it as no tiebreak.
    localparam tie_mode_t TIE_UNUSED    = 2'd3;

    typedef struct {
        logic [OBJ_W-1:0] word;
        logic             end_of_list;
    } cap_item_t;

    typedef struct {
        logic [POS_W-1:0] index;
        logic [OBJ_W-1:0] word;
        logic [UW_W-1:0]  power_uw;
    } chosen_t;

    // DUT ports; every input starts at a known value.
    logic                aclk;
    logic                aresetn        = 1'b0;
    logic                cfg_wr_en      = 1'b0;
    logic [CFG_A_W-1:0]  cfg_addr       = '0;
    logic [CFG_D_W-1:0]  cfg_wdata      = '0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [OBJ_W-1:0]    s_power_object = '0;
    logic                s_last_object  = 1'b0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [POS_W-1:0]    m_chosen_index;
    logic [OBJ_W-1:0]    m_chosen_object;
    logic [UW_W-1:0]     m_chosen_power_uw;

    // Items waiting to be offered, and chosen capabilities still to arrive.
    cap_item_t pending[$];
    chosen_t   chosen_q[$];

    // Local copy of the limit registers, kept in step with every write.
    logic [MV_W-1:0]    lim_request_mv   = RST_REQUEST_LIMIT;
    logic [MA_W-1:0]    lim_current_ma   = RST_CURRENT_LIMIT;
    logic [OPB_W-1:0]   lim_power_mw     = 18'd60000;
    logic [MV_W-1:0]    lim_spr_mv       = RST_SPR_LIMIT;
    logic [MV_W-1:0]    lim_valid_min_mv = RST_VALID_MIN;
    logic [MV_W-1:0]    lim_valid_max_mv = RST_VALID_MAX;
    tie_mode_t          lim_tie          = TIE_NONE;
    logic               lim_fixed_only   = 1'b0;

    // Scan state of the list in progress.
    logic [POS_W-1:0]   scan_pos   = '0;
    logic               scan_full  = 1'b0;
    logic [POS_W-1:0]   best_idx   = '0;
    logic [UW_W-1:0]    best_uw    = '0;
    logic [MV_W-1:0]    best_mv    = '0;
    logic [OBJ_W-1:0]   best_word  = '0;

    // Idle rates in percent, and the ticket that starts a long result stall.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_ticket = 0;

    int mismatches  = 0;
    int n_items     = 0;
    int n_lists     = 0;
    int n_results   = 0;
    int cycle_count = 0;

    usb_pd_source_cap_selector DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_power_object    (s_power_object),
        .s_last_object     (s_last_object),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_chosen_index    (m_chosen_index),
        .m_chosen_object   (m_chosen_object),
        .m_chosen_power_uw (m_chosen_power_uw)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Rate one capability at its list position and keep it if it beats the best.
    function automatic void rate_capability(input logic [OBJ_W-1:0] word,
                                            input logic [POS_W-1:0] pos);
        pdo_type_t       kind;
        int unsigned     mv;
        int unsigned     ma;
        longint unsigned uw;
        longint unsigned cap;
        logic            win;
        kind = word[31:30];
        mv   = 32'(word[19:10]) * MV_PER_UNIT;
        cap  = 64'(lim_power_mw) * UW_PER_MW;
        // Drop anything that the filters reject.
        if (kind == PDO_AUGMENTED)
            return;
        if (lim_fixed_only && kind != PDO_FIXED)
            return;
        if (mv == 0)
            return;
        if (pos < SPR_POSITIONS && mv > lim_spr_mv)
            return;
        if (mv < lim_valid_min_mv || mv > lim_valid_max_mv)
            return;
        if (mv > lim_request_mv)
            return;
        // Battery words carry power directly; the others carry a current to clamp.
        if (kind == PDO_BATTERY) begin
            uw = 64'(word[9:0]) * UW_PER_BATTERY_UNIT;
        end else begin
            ma = 32'(word[9:0]) * MA_PER_UNIT;
            if (ma > lim_current_ma)
                ma = lim_current_ma;
            uw = 64'(ma) * mv;
        end
        if (uw > cap)
            uw = cap;
        win = uw > best_uw;
        if (lim_tie == TIE_LOW && uw == best_uw && mv < best_mv)
            win = 1'b1;
        if (lim_tie == TIE_HIGH && uw == best_uw && mv > best_mv)
            win = 1'b1;
        if (win) begin
            best_idx  = pos;
            best_uw   = uw[UW_W-1:0];
            best_mv   = mv[MV_W-1:0];
            best_word = word;
        end
    endfunction

    // Advance the scan by one accepted item; close the list on its end marker.
    function automatic void take_capability(input logic [OBJ_W-1:0] word,
                                            input logic end_of_list);
        chosen_t pick;
        // Past the sixteenth capability, ignore items until the end marker.
        if (!scan_full) begin
            if (scan_pos == 0)
                best_word = word;
            rate_capability(word, scan_pos);
            if (scan_pos == MAX_OBJECTS - 1)
                scan_full = 1'b1;
            else
                scan_pos = scan_pos + 1'b1;
        end
        if (end_of_list) begin
            pick.index    = best_idx;
            pick.word     = best_word;
            pick.power_uw = best_uw;
            chosen_q.push_back(pick);
            n_lists++;
            scan_pos  = '0;
            scan_full = 1'b0;
            best_idx  = '0;
            best_uw   = '0;
            best_mv   = '0;
            best_word = '0;
        end
    endfunction

    function automatic logic [OBJ_W-1:0] pdo(input pdo_type_t kind,
                                             input logic [9:0] volt,
                                             input logic [9:0] amp);
        return {kind, 10'd0, volt, amp};
    endfunction

    // Mostly well-formed words at common voltages, with raw noise mixed in.
    function automatic logic [OBJ_W-1:0] random_capability();
        logic [OBJ_W-1:0] w;
        pdo_type_t        kind;
        logic [9:0]       volt;
        logic [9:0]       amp;
        int unsigned      pick;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            return $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 50)
            kind = PDO_FIXED;
        else if (pick < 68)
            kind = PDO_BATTERY;
        else if (pick < 88)
            kind = PDO_VARIABLE;
        else
            kind = PDO_AUGMENTED;
        case ($urandom_range(0, 9))
            0: volt = 10'($urandom_range(0, 1023));
            1: volt = 10'd0;
            2: volt = 10'd100;
            3: volt = 10'd180;
            4: volt = 10'd300;
            5: volt = 10'd400;
            6: volt = 10'd560;
            7: volt = 10'd720;
            8: volt = 10'd960;
            default: volt = 10'd1023;
        endcase
        // A small set of battery ratings and currents makes equal powers common.
        if (kind == PDO_BATTERY) begin
            case ($urandom_range(0, 3))
                0: amp = 10'd100;
                1: amp = 10'd240;
                2: amp = 10'd400;
                default: amp = 10'($urandom_range(0, 1023));
            endcase
        end else begin
            case ($urandom_range(0, 4))
                0: amp = 10'd0;
                1: amp = 10'd150;
                2: amp = 10'd300;
                3: amp = 10'd500;
                default: amp = 10'($urandom_range(0, 1023));
            endcase
        end
        w = pdo(kind, volt, amp);
        if ($urandom_range(0, 3) == 0)
            w[29:20] = 10'($urandom_range(0, 1023));
        return w;
    endfunction

    task automatic push_capability(input logic [OBJ_W-1:0] word, input logic end_of_list);
        cap_item_t it;
        it.word        = word;
        it.end_of_list = end_of_list;
        pending.push_back(it);
    endtask

    // Queue random lists until about the given number of items is waiting.
    task automatic queue_lists(input int target);
        int added;
        int len;
        int pick;
        added = 0;
        while (added < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                len = $urandom_range(1, 7);
            else if (pick < 92)
                len = $urandom_range(8, 16);
            else
                len = $urandom_range(17, 20);
            for (int i = 0; i < len; i++)
                push_capability(random_capability(), i == len - 1);
            added += len;
        end
    endtask

    // One register write, mirrored into the local copy as the write is driven.
    task automatic write_reg(input cfg_addr_t idx, input logic [CFG_D_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_REQUEST_LIMIT: lim_request_mv   = value[MV_W-1:0];
            CFG_CURRENT_LIMIT: lim_current_ma   = value[MA_W-1:0];
            CFG_POWER_LIMIT:   lim_power_mw     = value[OPB_W-1:0];
            CFG_SPR_LIMIT:     lim_spr_mv       = value[MV_W-1:0];
            CFG_VALID_MIN:     lim_valid_min_mv = value[MV_W-1:0];
            CFG_VALID_MAX:     lim_valid_max_mv = value[MV_W-1:0];
            CFG_TIE_MODE:      lim_tie          = value[1:0];
            CFG_FIXED_ONLY:    lim_fixed_only   = value[0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_limits(input int req, input int cur, input int pwr, input int spr,
                                input int vmin, input int vmax, input tie_mode_t tie,
                                input logic fixed);
        write_reg(CFG_REQUEST_LIMIT, CFG_D_W'(req));
        write_reg(CFG_CURRENT_LIMIT, CFG_D_W'(cur));
        write_reg(CFG_POWER_LIMIT, CFG_D_W'(pwr));
        write_reg(CFG_SPR_LIMIT, CFG_D_W'(spr));
        write_reg(CFG_VALID_MIN, CFG_D_W'(vmin));
        write_reg(CFG_VALID_MAX, CFG_D_W'(vmax));
        write_reg(CFG_TIE_MODE, CFG_D_W'(tie));
        write_reg(CFG_FIXED_ONLY, CFG_D_W'(fixed));
        @(negedge aclk);
    endtask

    // Wait until every queued item is taken and every chosen result is back,
    // then let the pipeline settle so a register write finds the block idle.
    task automatic drain();
        while (pending.size() != 0 || s_valid || chosen_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Input driver: hold the item until accepted, then offer the next one
    // unless this cycle is drawn as idle.
    always @(posedge aclk) begin : drive_items
        cap_item_t next_item;
        if (!aresetn) begin
            s_valid        <= 1'b0;
            s_power_object <= '0;
            s_last_object  <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                take_capability(s_power_object, s_last_object);
                n_items++;
            end
            if (!s_valid || s_ready) begin
                if (pending.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    next_item = pending.pop_front();
                    s_valid        <= 1'b1;
                    s_power_object <= next_item.word;
                    s_last_object  <= next_item.end_of_list;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random back-pressure, plus a long hold-off whenever
    // the stimulus process bumps the ticket.
    always @(posedge aclk) begin : drive_ready
        int hold_left;
        int hold_seen;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left = 0;
            hold_seen = 0;
        end else begin
            if (hold_seen != hold_ticket) begin
                hold_seen = hold_ticket;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= $urandom_range(0, 99) >= rx_idle_pct;
            end
        end
    end

    // Result monitor: compare each accepted result with the oldest prediction.
    always @(posedge aclk) begin : check_results
        chosen_t want;
        if (aresetn && m_valid && m_ready) begin
            if (chosen_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got index %0d object %h power %0d",
                         $time, m_chosen_index, m_chosen_object, m_chosen_power_uw);
                mismatches++;
            end else begin
                want = chosen_q.pop_front();
                n_results++;
                if (m_chosen_index !== want.index) begin
                    $display("%0t: chosen_index mismatch, expected %0d, got %0d",
                             $time, want.index, m_chosen_index);
                    mismatches++;
                end
                if (m_chosen_object !== want.word) begin
                    $display("%0t: chosen_object mismatch, expected %h, got %h",
                             $time, want.word, m_chosen_object);
                    mismatches++;
                end
                if (m_chosen_power_uw !== want.power_uw) begin
                    $display("%0t: chosen_power_uw mismatch, expected %0d, got %0d",
                             $time, want.power_uw, m_chosen_power_uw);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Stimulus: phases of lists under different limit settings.
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset limits: 20 V request and SPR ceiling, 3 A, 60 W, no tiebreak.
        tx_idle_pct = 29;
        rx_idle_pct = 50;
        // Nothing qualifies: report position 0 and the first word.
        push_capability(32'hFFFF_FFFF, 1'b1);
        // One of each type; battery 60 W ties the clamped variable, first one stays.
        push_capability(pdo(PDO_FIXED, 10'd100, 10'd300), 1'b0);
        push_capability(pdo(PDO_BATTERY, 10'd400, 10'd240), 1'b0);
        push_capability(pdo(PDO_VARIABLE, 10'd400, 10'd500), 1'b0);
        push_capability(pdo(PDO_FIXED, 10'd0, 10'd300), 1'b0);
        push_capability(32'h3FFF_FFFF, 1'b0);
        push_capability(pdo(PDO_FIXED, 10'd300, 10'd300), 1'b0);
        push_capability(pdo(PDO_AUGMENTED, 10'd400, 10'd1023), 1'b1);
        // All-ones battery and all-zero word are both skipped.
        push_capability(32'h7FFF_FFFF, 1'b0);
        push_capability(32'h0000_0000, 1'b0);
        push_capability(pdo(PDO_VARIABLE, 10'd100, 10'd100), 1'b1);
        // Single-item list at the full 60 W.
        push_capability(pdo(PDO_FIXED, 10'd400, 10'd1023), 1'b1);
        queue_lists(50);
        drain();

        // Everything zero: every capability is rejected, fixed-only, low tiebreak.
        apply_limits(0, 0, 0, 0, 0, 0, TIE_LOW, 1'b1);
        queue_lists(25);
        drain();

        // Zero current limit with high tiebreak: zero-power winners appear.
        tx_idle_pct = 50;
        rx_idle_pct = 29;
        apply_limits(51150, 0, 262143, 51150, 0, 51150, TIE_HIGH, 1'b0);
        queue_lists(60);
        drain();

        // Widest limits, SPR ceiling still at 20 V for the early positions.
        apply_limits(51150, 10230, 262143, 20000, 0, 51150, TIE_HIGH, 1'b0);
        queue_lists(70);
        drain();

        // Narrow window and low power cap: many capped ties, lower voltage wins.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        apply_limits(36000, 5000, 45000, 20000, 5000, 48000, TIE_LOW, 1'b0);
        queue_lists(70);
        drain();

        // Unused tiebreak code with fixed-only and random limits.
        apply_limits($urandom_range(10000, 51150), $urandom_range(0, 10230),
                     $urandom_range(0, 262143), $urandom_range(5000, 51150),
                     $urandom_range(0, 10000), $urandom_range(20000, 51150),
                     TIE_UNUSED, 1'b1);
        queue_lists(55);
        drain();

        // Random limits; stall the result side long enough to back up the input.
        apply_limits($urandom_range(10000, 51150), $urandom_range(1000, 10230),
                     $urandom_range(10000, 262143), $urandom_range(5000, 51150),
                     $urandom_range(0, 5000), $urandom_range(30000, 51150),
                     tie_mode_t'($urandom_range(0, 2)), 1'b0);
        hold_ticket++;
        queue_lists(60);
        drain();

        $display("summary: %0d capability items in %0d lists under 7 limit settings,",
                 n_items, n_lists);
        $display("summary: %0d chosen results checked, %0d mismatches", n_results, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
hdl/pdsel_pkg.sv
hdl/usb_pd_source_cap_selector.sv
tb/sv/tb_top.sv
